// ===== rtl/bba_pkg.sv =====
`timescale 1ns / 1ps

package bba_pkg;

  // Map geometry.
  localparam int MAX_BLOCKS = 1024;
  localparam int MAP_BYTES  = MAX_BLOCKS / 8;
  localparam int MAP_AW     = $clog2(MAP_BYTES);
  localparam int BLK_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = BLK_W + 1;
  localparam int BYTE_CW    = CNT_W - 3;

  // Request opcodes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Response status codes.
  localparam logic [1:0] ST_GRANT = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_FREED = 2'd2;

  typedef struct packed {
    logic             op;
    logic [BLK_W-1:0] block_index;
  } bba_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [BLK_W-1:0] granted_block;
  } bba_rsp_t;

endpackage

// ===== rtl/bitmap_block_allocator.sv =====
`timescale 1ns / 1ps
// One request at a time. Free: the map byte is read at accept, its bit cleared in S_FREE
// if in the live map, and the response word registered in S_DONE. Allocate: S_SCAN reads
// the map bytes in turn, one byte a cycle, and S_PASS ends each pass that finds nothing.
// req_ready rises in the same cycle as rsp_valid; a response word still
// waiting on rsp_ready holds the next result back. Synchronous reset clears the map
// (through per-byte valid bits), the hint and the rescan flag, and sets block_count to 1024.

module bitmap_block_allocator
  import bba_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  bba_req_t         req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output bba_rsp_t         rsp,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FREE = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_PASS = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam logic [7:0] FULL_BYTE = 8'hFF;

  logic [2:0]         state;
  logic [CNT_W-1:0]   block_count;
  logic [CNT_W-1:0]   hint;
  logic               rescan;
  logic               pass;
  logic [BYTE_CW-1:0] cur;
  logic [BYTE_CW-1:0] last;
  logic [BLK_W-1:0]   blk_idx;
  logic               free_ok;
  logic [1:0]         res_status;
  logic [BLK_W-1:0]   res_block;

  // Map memory: one read and one write port, registered read data. Each byte has a
  // valid bit that reset clears; a byte that was never written reads as all free.
  logic [7:0]          map_mem [MAP_BYTES];
  logic [MAP_BYTES-1:0] map_vld;
  logic [7:0]          rd_data;
  logic                rd_vld;
  logic [MAP_AW-1:0]   rd_addr;
  logic                mem_we;
  logic [MAP_AW-1:0]   mem_waddr;
  logic [7:0]          mem_wdata;

  logic [CNT_W-1:0]   cnt_clamp;
  logic [CNT_W-1:0]   cnt_live;
  logic [BYTE_CW-1:0] count_bytes;
  logic [BYTE_CW-1:0] start_byte;
  logic [CNT_W-1:0]   hint_up;
  logic [BYTE_CW-1:0] stop_raw;
  logic [BYTE_CW-1:0] stop_sel;
  logic [BYTE_CW-1:0] cur_inc;
  logic [7:0]         byte_now;
  logic [2:0]         zero_bit;
  logic               byte_full;
  logic               req_fire;

  assign req_ready = (state == S_IDLE);
  assign req_fire  = req_valid && req_ready;
  assign cfg_ready = 1'b1;

  // The live count is clamped to 8..MAX_BLOCKS and rounded down to whole bytes.
  always_comb begin
    if (block_count < CNT_W'(8)) begin
      cnt_clamp = CNT_W'(8);
    end else if (block_count > CNT_W'(MAX_BLOCKS)) begin
      cnt_clamp = CNT_W'(MAX_BLOCKS);
    end else begin
      cnt_clamp = block_count;
    end
  end

  assign cnt_live    = {cnt_clamp[CNT_W-1:3], 3'b000};
  assign count_bytes = cnt_clamp[CNT_W-1:3];
  assign start_byte  = hint[CNT_W-1:3];

  // The second pass ends at the byte that holds the hint, rounded up; an empty or
  // too large range falls back to the whole live map.
  assign hint_up  = hint + CNT_W'(7);
  assign stop_raw = hint_up[CNT_W-1:3];
  assign stop_sel = (stop_raw == '0 || stop_raw > count_bytes) ? count_bytes : stop_raw;

  assign cur_inc   = cur + BYTE_CW'(1);
  assign byte_now  = rd_vld ? rd_data : 8'h00;
  assign byte_full = (byte_now == FULL_BYTE);

  // Lowest clear bit of the byte under scan.
  always_comb begin
    zero_bit = 3'd0;
    for (int j = 7; j >= 0; j--) begin
      if (!byte_now[j]) begin
        zero_bit = 3'(j);
      end
    end
  end

  // Read address: the next byte the sequencer will look at.
  always_comb begin
    rd_addr = '0;
    case (state)
      S_IDLE: begin
        if (req.op == OP_FREE) begin
          rd_addr = req.block_index[BLK_W-1:3];
        end else begin
          rd_addr = start_byte[MAP_AW-1:0];
        end
      end
      S_SCAN: begin
        rd_addr = cur_inc[MAP_AW-1:0];
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  // Write port: clear a bit on free, set the granted bit on a hit.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = byte_now;
    case (state)
      S_FREE: begin
        mem_we    = free_ok;
        mem_waddr = blk_idx[BLK_W-1:3];
        mem_wdata = byte_now & ~(8'h01 << blk_idx[2:0]);
      end
      S_SCAN: begin
        mem_we    = !byte_full;
        mem_waddr = cur[MAP_AW-1:0];
        mem_wdata = byte_now | (8'h01 << zero_bit);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= map_mem[rd_addr];
    rd_vld  <= map_vld[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      map_vld <= '0;
    end else if (mem_we) begin
      map_vld[mem_waddr] <= 1'b1;
    end
  end

  // Sequencer. The scan reads one map byte per cycle; the compare and priority
  // encode on that byte is the shared unit reused across both passes.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rsp_valid   <= 1'b0;
      hint        <= '0;
      rescan      <= 1'b0;
      block_count <= CNT_W'(1024);
    end else begin
      if (cfg_valid && cfg_ready) begin
        block_count <= cfg_data;
      end
      // In S_DONE the response register is handled by that state alone.
      if (rsp_ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_fire) begin
            if (req.op == OP_FREE) begin
              blk_idx <= req.block_index;
              free_ok <= ({1'b0, req.block_index} < cnt_live);
              state   <= S_FREE;
            end else begin
              pass  <= 1'b0;
              cur   <= start_byte;
              last  <= count_bytes;
              state <= (start_byte < count_bytes) ? S_SCAN : S_PASS;
            end
          end
        end
        S_FREE: begin
          if (free_ok) begin
            rescan <= 1'b1;
          end
          res_status <= ST_FREED;
          res_block  <= '0;
          state      <= S_DONE;
        end
        S_SCAN: begin
          if (!byte_full) begin
            hint       <= {1'b0, cur[MAP_AW-1:0], zero_bit} + CNT_W'(1);
            res_status <= ST_GRANT;
            res_block  <= {cur[MAP_AW-1:0], zero_bit};
            state      <= S_DONE;
          end else if (cur_inc < last) begin
            cur <= cur_inc;
          end else begin
            state <= S_PASS;
          end
        end
        S_PASS: begin
          // A free since the last wrap earns one more pass from block 0.
          if (!pass && rescan) begin
            rescan <= 1'b0;
            pass   <= 1'b1;
            cur    <= '0;
            last   <= stop_sel;
            state  <= S_SCAN;
          end else begin
            res_status <= ST_FULL;
            res_block  <= '0;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          // Hold until the response register is free.
          if (!rsp_valid || rsp_ready) begin
            rsp_valid         <= 1'b1;
            rsp.status        <= res_status;
            rsp.granted_block <= res_block;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/bba_checker.sv =====
`timescale 1ns / 1ps

module bba_checker
  import bba_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_ready,
  input bba_req_t         req,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input bba_rsp_t         rsp,
  input logic             cfg_valid,
  input logic             cfg_ready,
  input logic [CNT_W-1:0] cfg_data
);

  // No response word right after reset.
  a_rst_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // A stalled response word holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // Only a grant carries a block number.
  a_blk_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_GRANT |-> rsp.granted_block == '0)
    else $error("block number without grant");

  // Status is one of the three defined codes.
  a_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.status == ST_GRANT || rsp.status == ST_FULL ||
                   rsp.status == ST_FREED))
    else $error("undefined status code");

  // One request at a time: the block is busy right after an accept.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (.*);
